// ===== rtl/mmq_pkg.sv =====
// Shared types and constants for the min/max 8-bit quantizer.
// No dependencies; imported by mmq_div_pipe and min_max_quantizer_u8.
package mmq_pkg;

	localparam int SAMPLE_BITS = 32;
	localparam int CODE_BITS   = 8;
	localparam int CFG_IDX_BITS = 1;

	// sample - range_min and range_max - range_min need one extra bit
	localparam int DIFF_BITS = SAMPLE_BITS + 1;
	// 510*diff + span, diff and span below 2^SAMPLE_BITS when used
	localparam int NUM_BITS  = DIFF_BITS + 9;
	// divisor 2*span pre-shifted by CODE_BITS-1 for the first quotient bit
	localparam int DSH_BITS  = DIFF_BITS + CODE_BITS;
	localparam int DIV_STEPS = CODE_BITS;

	localparam logic [CFG_IDX_BITS-1:0] REG_RANGE_MIN = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] REG_RANGE_MAX = CFG_IDX_BITS'(1);

	localparam logic signed [SAMPLE_BITS-1:0] RANGE_MIN_RST = SAMPLE_BITS'(0);
	localparam logic signed [SAMPLE_BITS-1:0] RANGE_MAX_RST = SAMPLE_BITS'(65536);

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          last_in;
	} in_beat_t;

	typedef struct packed {
		logic [CODE_BITS-1:0] code;
		logic                 last_out;
	} out_beat_t;

	// one item in flight through the divider
	typedef struct packed {
		logic [NUM_BITS-1:0]  rem;
		logic [DSH_BITS-1:0]  dsh;
		logic [CODE_BITS-1:0] quo;
		logic                 zero;
		logic                 full;
		logic                 last;
	} div_t;

endpackage

// ===== rtl/min_max_quantizer_u8.sv =====
// Min/max linear quantizer: signed fixed-point samples to 8-bit codes.
// Pipeline: 2 prep stages then 8 divide stages from sample beat to result beat.
// Throughput: one beat per cycle when unstalled; one quotient bit per divider stage.
// Reset (arst_n low, async): all stage valid bits clear, range_min = 0,
// range_max = 65536. Depends on mmq_pkg and mmq_div_pipe.
module min_max_quantizer_u8
	import mmq_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	// config write port
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [SAMPLE_BITS-1:0]  cfg_data,
	// sample channel
	input  logic                    sample_valid,
	output logic                    sample_stall,
	input  in_beat_t                sample_beat,
	// result channel
	output logic                    result_valid,
	input  logic                    result_stall,
	output out_beat_t               result_beat
);

	// ---------------------------------------------------------------
	// Config registers; the user must write them only while the pipe is idle (not enforced).
	// ---------------------------------------------------------------
	logic signed [SAMPLE_BITS-1:0] range_min_q;
	logic signed [SAMPLE_BITS-1:0] range_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_min_q <= RANGE_MIN_RST;
			range_max_q <= RANGE_MAX_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RANGE_MIN: range_min_q <= cfg_data;
				REG_RANGE_MAX: range_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Stall chain: a stage advances when empty or when the next one does.
	// ---------------------------------------------------------------
	logic en_s1, en_s2;
	logic div_ready;
	logic valid_s1, valid_s2;

	assign en_s2        = !valid_s2 || div_ready;
	assign en_s1        = !valid_s1 || en_s2;
	assign sample_stall = !en_s1;

	// ---------------------------------------------------------------
	// Stage 1: signed offsets, one bit wider so nothing wraps.
	// ---------------------------------------------------------------
	logic signed [DIFF_BITS-1:0] diff_s1, span_s1;
	logic                        last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && sample_valid) begin
			diff_s1 <= DIFF_BITS'(sample_beat.sample) - DIFF_BITS'(range_min_q);
			span_s1 <= DIFF_BITS'(range_max_q) - DIFF_BITS'(range_min_q);
			last_s1 <= sample_beat.last_in;
		end
	end

	// ---------------------------------------------------------------
	// Stage 2: floor span at 1 LSB, saturation flags, dividend/divisor.
	// code = floor((510*diff + span) / (2*span)); both operands only
	// matter when 0 < diff < span, so diff and span fit SAMPLE_BITS
	// unsigned there. Divisor is pre-shifted for the MSB quotient bit.
	// ---------------------------------------------------------------
	logic signed [DIFF_BITS-1:0] span_f;
	logic [NUM_BITS-1:0]         diff_w;
	logic [NUM_BITS-1:0]         num_c;
	div_t                        div_s2;

	assign span_f = (span_s1 < DIFF_BITS'(1)) ? DIFF_BITS'(1) : span_s1;
	assign diff_w = NUM_BITS'(unsigned'(diff_s1));
	// 510*diff as (diff << 9) - (diff << 1)
	assign num_c  = (diff_w << 9) - (diff_w << 1) + NUM_BITS'(unsigned'(span_f));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			div_s2.rem  <= num_c;
			div_s2.dsh  <= DSH_BITS'(unsigned'(span_f)) << CODE_BITS;
			div_s2.quo  <= '0;
			div_s2.zero <= diff_s1 <= DIFF_BITS'(0);
			div_s2.full <= diff_s1 >= span_f;
			div_s2.last <= last_s1;
		end
	end

	// ---------------------------------------------------------------
	// Stages 3..10: divider; its last stage holds the result beat.
	// ---------------------------------------------------------------
	mmq_div_pipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s2),
		.in_data   (div_s2),
		.in_ready  (div_ready),
		.out_valid (result_valid),
		.out_beat  (result_beat),
		.out_stall (result_stall)
	);

endmodule

// ===== rtl/mmq_div_pipe.sv =====
// Pipelined restoring divider: one quotient bit per stage, DIV_STEPS stages.
// Depends on mmq_pkg; the last stage register is the result beat register.
module mmq_div_pipe
	import mmq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  div_t      in_data,
	output logic      in_ready,
	output logic      out_valid,
	output out_beat_t out_beat,
	input  logic      out_stall
);

	logic [DIV_STEPS-1:0] valid_s;
	logic [DIV_STEPS-1:0] en;
	div_t                 data_s [DIV_STEPS];
	div_t                 nxt    [DIV_STEPS];

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		div_t src;
		logic src_v;
		logic ge;

		if (k == 0) begin : g_first
			assign src   = in_data;
			assign src_v = in_valid;
		end else begin : g_rest
			assign src   = data_s[k-1];
			assign src_v = valid_s[k-1];
		end

		if (k == DIV_STEPS - 1) begin : g_tail
			assign en[k] = !valid_s[k] || !out_stall;
		end else begin : g_mid
			assign en[k] = !valid_s[k] || en[k+1];
		end

		assign ge = src.rem >= NUM_BITS'(src.dsh);

		always_comb begin
			nxt[k]      = src;
			nxt[k].rem  = ge ? (src.rem - NUM_BITS'(src.dsh)) : src.rem;
			nxt[k].dsh  = src.dsh >> 1;
			nxt[k].quo  = {src.quo[CODE_BITS-2:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en[k]) begin
				valid_s[k] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en[k] && src_v) begin
				data_s[k] <= nxt[k];
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = valid_s[DIV_STEPS-1];

	// saturation overrides the quotient at the ends of the range
	always_comb begin
		out_beat.last_out = data_s[DIV_STEPS-1].last;
		priority if (data_s[DIV_STEPS-1].zero) begin
			out_beat.code = '0;
		end else if (data_s[DIV_STEPS-1].full) begin
			out_beat.code = '1;
		end else begin
			out_beat.code = data_s[DIV_STEPS-1].quo;
		end
	end

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for min_max_quantizer_u8: random and directed samples
// under several min/max settings, with idling and stalls on both channels.
// Depends on mmq_pkg and the quantizer RTL.
`timescale 1ns / 100ps

module tb;
	import mmq_pkg::*;

	localparam int PHASE_BEATS = 106;   // random beats per config setting
	localparam int LONG_HOLD   = 300;   // receiver hold-off, long enough to back up the pipe
	localparam int TAIL_CYCLES = 20;    // margin left after the drain

	logic clk          = 1'b0;
	logic arst_n       = 1'b0;
	logic cfg_we       = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [SAMPLE_BITS-1:0]  cfg_data  = '0;
	logic      sample_valid = 1'b0;
	logic      sample_stall;
	in_beat_t  sample_beat  = '0;
	logic      result_valid;
	logic      result_stall = 1'b0;
	out_beat_t result_beat;

	// Shadow copy of the range registers, updated as each write goes out.
	logic signed [SAMPLE_BITS-1:0] bound_lo = RANGE_MIN_RST;
	logic signed [SAMPLE_BITS-1:0] bound_hi = RANGE_MAX_RST;

	in_beat_t  sample_q[$];      // beats waiting to be offered
	out_beat_t code_expect_q[$]; // predicted results, oldest first

	int   fail_count   = 0;
	int   beats_sent   = 0;
	logic beat_taken   = 1'b0;
	int   gap_left     = 0;
	int   stall_left   = 0;
	int   hold_left    = 0;
	int   hold_trigger = 32'h7fff_ffff;
	bit   hold_done    = 1'b0;
	bit   quiet        = 1'b0; // no idling on either side while set

	min_max_quantizer_u8 dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_beat  (sample_beat),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_beat  (result_beat)
	);

	always #5 clk = ~clk;

	// Expected code: round-half-up of diff*255/span, done as
	// floor((510*diff + span) / (2*span)), saturated at both ends.
	// Span is floored to one LSB, so a reversed or empty range acts as a step.
	function automatic out_beat_t quantize_beat(in_beat_t b);
		longint    lo, span, diff;
		out_beat_t r;
		lo   = longint'(bound_lo);
		span = longint'(bound_hi) - lo;
		diff = longint'(b.sample) - lo;
		if (span < 1)
			span = 1;
		if (diff <= 0)
			r.code = '0;
		else if (diff >= span)
			r.code = '1;
		else
			r.code = CODE_BITS'((diff * 510 + span) / (2 * span));
		r.last_out = b.last_in;
		return r;
	endfunction

	// Idle length: mostly none, some short, a few long.
	function automatic int idle_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (quiet || pick < 65)
			return 0;
		else if (pick < 93)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// Sample biased toward the configured range so codes spread over 0..255,
	// with full-width noise and values hugging each bound.
	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(longint lo, longint hi);
		longint    span, v;
		bit [63:0] r64;
		int        pick;
		span = hi - lo;
		pick = $urandom_range(0, 9);
		r64  = {$urandom(), $urandom()};
		if (span < 1)
			v = (pick < 5) ? lo + longint'($urandom_range(0, 6)) - 3 : longint'(int'($urandom()));
		else if (pick < 6)
			v = lo + longint'(r64 % 64'(span + 1));
		else if (pick == 6)
			v = longint'(int'($urandom()));
		else if (pick == 7)
			v = lo + longint'($urandom_range(0, 6)) - 3;
		else if (pick == 8)
			v = hi + longint'($urandom_range(0, 6)) - 3;
		else
			v = lo - longint'(r64 % 64'(span + 1)) + hi - lo + longint'(r64[7:0] % 3) - 1;
		if (v > 64'sd2147483647)
			v = 64'sd2147483647;
		if (v < -64'sd2147483648)
			v = -64'sd2147483648;
		return SAMPLE_BITS'(v);
	endfunction

	task automatic note_failure(input string msg);
		if (fail_count < 10)
			$display("%0t: %s", $realtime, msg);
		fail_count++;
	endtask

	task automatic queue_beat(input logic signed [SAMPLE_BITS-1:0] s, input logic l);
		in_beat_t b;
		b.sample  = s;
		b.last_in = l;
		sample_q.push_back(b);
	endtask

	// Register writes go out at a falling edge and land on the next rising edge.
	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic signed [SAMPLE_BITS-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		if (idx == REG_RANGE_MIN)
			bound_lo = val;
		else
			bound_hi = val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_range(input logic signed [SAMPLE_BITS-1:0] lo,
			input logic signed [SAMPLE_BITS-1:0] hi);
		write_reg(REG_RANGE_MIN, lo);
		write_reg(REG_RANGE_MAX, hi);
	endtask

	// Sender pauses here until every queued beat is out and every result is back.
	// Every beat yields exactly one result, so an empty expect queue means idle.
	task automatic wait_drained();
		while (sample_q.size() != 0 || sample_valid || code_expect_q.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Sample channel driver: a new beat only after the current one was taken,
	// then an optional idle gap before the next.
	always @(negedge clk) begin
		if (arst_n && (!sample_valid || beat_taken)) begin
			if (gap_left != 0 || sample_q.size() == 0) begin
				sample_valid <= 1'b0;
				if (gap_left != 0)
					gap_left--;
			end else begin
				sample_beat  <= sample_q.pop_front();
				sample_valid <= 1'b1;
				gap_left = idle_len();
			end
		end
	end

	// Result channel stall: random stalls, plus one long hold-off counted here
	// while the sender keeps offering, so the pipe fills and stalls its input.
	always @(negedge clk) begin
		if (!hold_done && beats_sent >= hold_trigger) begin
			hold_left = LONG_HOLD;
			hold_done = 1'b1;
		end
		if (hold_left != 0) begin
			result_stall <= 1'b1;
			hold_left--;
		end else if (stall_left != 0) begin
			result_stall <= 1'b1;
			stall_left--;
		end else begin
			stall_left = idle_len();
			result_stall <= (stall_left != 0);
			if (stall_left != 0)
				stall_left--;
		end
	end

	// Both channels sampled at the rising edge: accepted samples are predicted
	// with the current range, accepted results are checked against the oldest.
	always @(posedge clk) begin
		out_beat_t want;
		beat_taken <= arst_n && sample_valid && !sample_stall;
		if (arst_n && sample_valid && !sample_stall) begin
			code_expect_q.push_back(quantize_beat(sample_beat));
			beats_sent++;
		end
		if (arst_n && result_valid && !result_stall) begin
			if (code_expect_q.size() == 0) begin
				note_failure($sformatf("unexpected result code=%0d last=%0b",
					result_beat.code, result_beat.last_out));
			end else begin
				want = code_expect_q.pop_front();
				if (result_beat.code !== want.code || result_beat.last_out !== want.last_out)
					note_failure($sformatf("code exp %0d got %0d, last exp %0b got %0b",
						want.code, result_beat.code, want.last_out, result_beat.last_out));
			end
		end
	end

	initial begin
		longint lo, hi;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// Reset range 0..65536: extremes of the sample field and the boundaries.
		queue_beat(32'sd0, 1'b0);
		queue_beat(-32'sd1, 1'b1);
		queue_beat(32'sd1, 1'b0);
		queue_beat(32'sd32768, 1'b0);
		queue_beat(32'sd65535, 1'b1);
		queue_beat(32'sd65536, 1'b0);
		queue_beat(32'sd65537, 1'b0);
		queue_beat(32'sh7fff_ffff, 1'b1);
		queue_beat(32'sh8000_0000, 1'b0);
		wait_drained();

		// Span of 510: diff 1 lands exactly on a half code and must round up.
		set_range(32'sd0, 32'sd510);
		queue_beat(32'sd1, 1'b0);
		queue_beat(32'sd3, 1'b0);
		queue_beat(32'sd255, 1'b1);
		queue_beat(32'sd509, 1'b0);
		queue_beat(32'sd510, 1'b1);
		wait_drained();

		// Empty range: span floors to one LSB, a step at the minimum.
		set_range(32'sd100, 32'sd100);
		queue_beat(32'sd99, 1'b0);
		queue_beat(32'sd100, 1'b0);
		queue_beat(32'sd101, 1'b1);
		wait_drained();

		// Reversed range behaves the same way.
		set_range(32'sd5, -32'sd5);
		queue_beat(32'sd4, 1'b1);
		queue_beat(32'sd5, 1'b0);
		queue_beat(32'sd6, 1'b0);
		queue_beat(32'sh8000_0000, 1'b1);
		queue_beat(32'sh7fff_ffff, 1'b0);
		wait_drained();

		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: begin lo = -64'sd2147483648; hi = 64'sd2147483647; end
				1: begin lo = 64'sd2147483647;  hi = -64'sd2147483648; end
				2: begin lo = -3 * 65536;       hi = 5 * 65536; end
				3: begin
					lo = longint'($urandom_range(0, 2 ** 21)) - 2 ** 20;
					hi = lo + longint'($urandom_range(1, 600));
				end
				4: begin lo = longint'(int'($urandom())); hi = longint'(int'($urandom())); end
				5: begin lo = longint'($urandom_range(0, 1000)) - 500; hi = lo + 1; end
				6: begin lo = -200; hi = 55; end
				default: begin
					lo = longint'($urandom_range(0, 2 ** 31 - 1)) - 2 ** 30;
					hi = lo + longint'($urandom_range(1, 2 ** 30));
				end
			endcase
			set_range(SAMPLE_BITS'(lo), SAMPLE_BITS'(hi));
			quiet = (phase == 2);
			if (phase == 3)
				hold_trigger = beats_sent + 20;
			for (int n = 0; n < PHASE_BEATS; n++)
				queue_beat(pick_sample(longint'(bound_lo), longint'(bound_hi)),
					$urandom_range(0, 7) == 0);
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (code_expect_q.size() != 0)
			note_failure($sformatf("%0d results never arrived", code_expect_q.size()));
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Watchdog: several times the slowest legal run.
	initial begin
		#5000000;
		$display("tb: failure");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/mmq_pkg.sv
rtl/mmq_div_pipe.sv
rtl/min_max_quantizer_u8.sv
bench/tb.sv
